/* hw/rtl/fct_pkg.sv */
// Package: shared types and constants of the fanout completion tracker.
`timescale 1ns / 1ps
package fct_pkg;

  localparam int unsigned FANOUT  = 4;   // leaves per request, a power of two
  localparam int unsigned SLOTS   = 64;  // tracking slots, a power of two
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned FAN_SH  = $clog2(FANOUT);
  localparam int unsigned LEAF_W  = 2;
  localparam int unsigned NUM_WORK = 4;
  localparam int unsigned REM_W   = 3;
  localparam int unsigned QDEPTH  = 2;

  typedef enum logic {
    CMD_REQUEST  = 1'b0,
    CMD_RESPONSE = 1'b1
  } fct_cmd_e;

  typedef enum logic [1:0] {
    KIND_DOWN   = 2'd0,
    KIND_REPLY  = 2'd1,
    KIND_REJECT = 2'd2
  } fct_kind_e;

  typedef struct packed {
    fct_cmd_e     command;
    logic [63:0]  work_0;
    logic [63:0]  work_1;
    logic [63:0]  work_2;
    logic [63:0]  work_3;
    logic [63:0]  tag;
    logic [63:0]  end_stamp;
    logic [31:0]  cpu_number;
    logic [63:0]  leaf_delay;
    logic [63:0]  local_delay;
  } fct_in_t;

  typedef struct packed {
    fct_kind_e    kind;
    logic [1:0]   leaf;
    logic [63:0]  work_amount;
    logic [63:0]  out_index;
    logic [63:0]  out_stamp;
    logic [31:0]  out_cpu;
    logic [63:0]  total_delay;
    logic         last;
  } fct_out_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    fct_cmd_e                        command;
    logic [SLOT_W-1:0]               slot;
    logic [NUM_WORK-1:0][63:0]       work;
    logic [63:0]                     tag;
    logic [63:0]                     stamp;
    logic [31:0]                     cpu;
    logic [63:0]                     leaf_delay;
    logic [63:0]                     local_delay;
  } fct_job_t;

  typedef struct packed {
    logic [REM_W-1:0] remaining;
    logic [63:0]      max_delay;
  } fct_cnt_t;

  typedef struct packed {
    logic [63:0] up_id;
    logic [63:0] stamp;
    logic [31:0] cpu;
  } fct_meta_t;

endpackage

/* hw/rtl/fct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fct_front.sv */
// Front end: accepts input words, decodes the command and finds the response slot.
`timescale 1ns / 1ps
module fct_front import fct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fct_in_t  in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output fct_job_t job_o
);

  logic     valid_q, valid_d;
  fct_job_t job_q, job_d;
  logic     take;

  assign in_ready_o = !valid_q || job_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    job_d = job_q;
    valid_d = valid_q && !job_ready_i;
    if (take) begin
      valid_d           = 1'b1;
      job_d.command     = in_data_i.command;
      // Slot of a downstream index: drop the leaf bits, keep the slot bits.
      job_d.slot        = in_data_i.tag[FAN_SH +: SLOT_W];
      job_d.work        = {in_data_i.work_3, in_data_i.work_2,
                           in_data_i.work_1, in_data_i.work_0};
      job_d.tag         = in_data_i.tag;
      job_d.stamp       = in_data_i.end_stamp;
      job_d.cpu         = in_data_i.cpu_number;
      job_d.leaf_delay  = in_data_i.leaf_delay;
      job_d.local_delay = in_data_i.local_delay;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

/* hw/rtl/fct_queue.sv */
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module fct_queue import fct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  fct_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output fct_job_t pop_job_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  fct_job_t          entry_q [QDEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_job_o    = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_job_i;
    end
  end

endmodule

/* hw/rtl/fct_back.sv */
// Back end: slot bookkeeping, downstream fan-out and upstream replies.
`timescale 1ns / 1ps
module fct_back import fct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  fct_job_t job_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fct_out_t out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_REJECT   = 5'b00100,
    S_SCATTER  = 5'b01000,
    S_READ     = 5'b10000
  } fct_state_e;

  localparam int unsigned CNT_BITS  = $bits(fct_cnt_t);
  localparam int unsigned META_BITS = $bits(fct_meta_t);

  fct_state_e          state_q, state_d;
  fct_job_t            job_q, job_d;
  logic [63:0]         next_q, next_d;
  logic [63:0]         base_q, base_d;
  logic [LEAF_W-1:0]   leaf_q, leaf_d;
  logic [SLOTS-1:0]    busy_q, busy_d;
  fct_out_t            out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                out_free;
  logic [SLOT_W-1:0]   req_slot;
  logic                cnt_we, meta_we;
  logic [SLOT_W-1:0]   waddr;
  fct_cnt_t            cnt_wdata, cnt_rd;
  fct_meta_t           meta_wdata, meta_rd;
  logic [CNT_BITS-1:0] cnt_rdata;
  logic [META_BITS-1:0] meta_rdata;
  logic [63:0]         new_max;
  logic [REM_W-1:0]    new_rem;

  assign out_free = !out_valid_q || out_ready_i;
  assign req_slot = next_q[FAN_SH +: SLOT_W];
  assign cnt_rd   = fct_cnt_t'(cnt_rdata);
  assign meta_rd  = fct_meta_t'(meta_rdata);
  assign new_max  = (job_q.leaf_delay > cnt_rd.max_delay) ? job_q.leaf_delay
                                                          : cnt_rd.max_delay;
  assign new_rem  = cnt_rd.remaining - REM_W'(1);

  assign job_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    next_d      = next_q;
    base_d      = base_q;
    leaf_d      = leaf_q;
    busy_d      = busy_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_we      = 1'b0;
    meta_we     = 1'b0;
    waddr       = job_q.slot;
    cnt_wdata   = '0;
    meta_wdata  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_d   = job_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (job_q.command == CMD_REQUEST) begin
          if (busy_q[req_slot]) begin
            state_d = S_REJECT;
          end else begin
            // Open the slot and start the fan-out at the current index.
            waddr                = req_slot;
            cnt_we               = 1'b1;
            meta_we              = 1'b1;
            cnt_wdata.remaining  = REM_W'(FANOUT);
            cnt_wdata.max_delay  = '0;
            meta_wdata.up_id     = job_q.tag;
            meta_wdata.stamp     = job_q.stamp;
            meta_wdata.cpu       = job_q.cpu;
            busy_d[req_slot]     = 1'b1;
            base_d               = next_q;
            next_d               = next_q + 64'(FANOUT);
            leaf_d               = '0;
            state_d              = S_SCATTER;
          end
        end else begin
          // Drop a response to an idle slot; otherwise read its record.
          state_d = busy_q[job_q.slot] ? S_READ : S_IDLE;
        end
      end
      S_REJECT: begin
        if (out_free) begin
          out_d           = '0;
          out_d.kind      = KIND_REJECT;
          out_d.out_index = job_q.tag;
          out_d.last      = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SCATTER: begin
        if (out_free) begin
          out_d             = '0;
          out_d.kind        = KIND_DOWN;
          out_d.leaf        = leaf_q;
          out_d.work_amount = job_q.work[leaf_q];
          out_d.out_index   = base_q + 64'(leaf_q);
          out_d.last        = (leaf_q == LEAF_W'(FANOUT - 1));
          out_valid_d       = 1'b1;
          leaf_d            = leaf_q + LEAF_W'(1);
          if (leaf_q == LEAF_W'(FANOUT - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          cnt_we              = 1'b1;
          cnt_wdata.remaining = new_rem;
          cnt_wdata.max_delay = new_max;
          if (new_rem == '0) begin
            busy_d[job_q.slot] = 1'b0;
            out_d              = '0;
            out_d.kind         = KIND_REPLY;
            out_d.out_index    = meta_rd.up_id;
            out_d.out_stamp    = meta_rd.stamp;
            out_d.out_cpu      = meta_rd.cpu;
            out_d.total_delay  = job_q.local_delay + new_max;
            out_d.last         = 1'b1;
            out_valid_d        = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  fct_ram #(
    .Width(CNT_BITS),
    .Depth(SLOTS)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(waddr),
    .wdata_i(CNT_BITS'(cnt_wdata)),
    .raddr_i(job_q.slot),
    .rdata_o(cnt_rdata)
  );

  fct_ram #(
    .Width(META_BITS),
    .Depth(SLOTS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(waddr),
    .wdata_i(META_BITS'(meta_wdata)),
    .raddr_i(job_q.slot),
    .rdata_o(meta_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_q      <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    base_q <= base_d;
    leaf_q <= leaf_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/fanout_completion_tracker_core.sv */
// A word reaches the back end via the front register and the job queue; its first
// result goes from DISPATCH via SCATTER, REJECT or READ to the output register, alike
// for a request, a reject and a reply. The back end sequencer takes a new job only in
// IDLE, so it finishes one job before the next; the output register stalls it. Reset
// clears all slots to idle and the downstream index to zero.
`timescale 1ns / 1ps
module fanout_completion_tracker_core import fct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fct_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fct_out_t out_data_o
);

  logic     fr_valid, fr_ready;
  fct_job_t fr_job;
  logic     bk_valid, bk_ready;
  fct_job_t bk_job;

  fct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_valid_o(fr_valid),
    .job_ready_i(fr_ready),
    .job_o      (fr_job)
  );

  fct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_job_i  (fr_job),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_job_o   (bk_job)
  );

  fct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(bk_valid),
    .job_ready_o(bk_ready),
    .job_i      (bk_job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

/* tb/sv/fct_checker.sv */
// Checker: watches both channels, predicts tracker output words and compares them.
`timescale 1ns / 1ps
module fct_checker import fct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  fct_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  fct_out_t    out_data_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned owed_cnt_o
);

  // Predicted tracker state
  logic [63:0]      down_idx;
  bit               slot_busy [SLOTS];
  logic [REM_W-1:0] slot_left [SLOTS];
  logic [63:0]      slot_max [SLOTS];
  logic [63:0]      slot_id [SLOTS];
  logic [63:0]      slot_stamp [SLOTS];
  logic [31:0]      slot_cpu [SLOTS];

  fct_out_t owed_words [$];
  fct_out_t want;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, exp_val);
    mismatch_cnt_o++;
  endtask

  task automatic compare_word(input fct_out_t got, input fct_out_t exp_word);
    if (got.kind !== exp_word.kind) begin
      report_mismatch("kind", 64'(got.kind), 64'(exp_word.kind));
    end
    if (got.leaf !== exp_word.leaf) begin
      report_mismatch("leaf", 64'(got.leaf), 64'(exp_word.leaf));
    end
    if (got.work_amount !== exp_word.work_amount) begin
      report_mismatch("work_amount", got.work_amount, exp_word.work_amount);
    end
    if (got.out_index !== exp_word.out_index) begin
      report_mismatch("out_index", got.out_index, exp_word.out_index);
    end
    if (got.out_stamp !== exp_word.out_stamp) begin
      report_mismatch("out_stamp", got.out_stamp, exp_word.out_stamp);
    end
    if (got.out_cpu !== exp_word.out_cpu) begin
      report_mismatch("out_cpu", 64'(got.out_cpu), 64'(exp_word.out_cpu));
    end
    if (got.total_delay !== exp_word.total_delay) begin
      report_mismatch("total_delay", got.total_delay, exp_word.total_delay);
    end
    if (got.last !== exp_word.last) begin
      report_mismatch("last", 64'(got.last), 64'(exp_word.last));
    end
  endtask

  task automatic predict_tracker(input fct_in_t w);
    logic [SLOT_W-1:0] s;
    fct_out_t          r;
    int                i;
    if (w.command == CMD_REQUEST) begin
      s = down_idx[FAN_SH +: SLOT_W];
      if (slot_busy[s]) begin
        r = '0;
        r.kind = KIND_REJECT;
        r.out_index = w.tag;
        r.last = 1'b1;
        owed_words = {owed_words, r};
      end else begin
        slot_busy[s]  = 1'b1;
        slot_left[s]  = REM_W'(FANOUT);
        slot_max[s]   = '0;
        slot_id[s]    = w.tag;
        slot_stamp[s] = w.end_stamp;
        slot_cpu[s]   = w.cpu_number;
        for (i = 0; i < FANOUT; i++) begin
          r = '0;
          r.kind = KIND_DOWN;
          r.leaf = LEAF_W'(i);
          case (i)
            0:       r.work_amount = w.work_0;
            1:       r.work_amount = w.work_1;
            2:       r.work_amount = w.work_2;
            default: r.work_amount = w.work_3;
          endcase
          r.out_index = down_idx + 64'(i);
          r.last = (i == FANOUT - 1);
          owed_words = {owed_words, r};
        end
        down_idx = down_idx + 64'(FANOUT);
      end
    end else begin
      s = w.tag[FAN_SH +: SLOT_W];
      // Drop responses to idle slots; any response to a busy slot counts.
      if (slot_busy[s]) begin
        if (w.leaf_delay > slot_max[s]) slot_max[s] = w.leaf_delay;
        slot_left[s] = slot_left[s] - REM_W'(1);
        if (slot_left[s] == '0) begin
          slot_busy[s] = 1'b0;
          r = '0;
          r.kind = KIND_REPLY;
          r.out_index = slot_id[s];
          r.out_stamp = slot_stamp[s];
          r.out_cpu = slot_cpu[s];
          r.total_delay = w.local_delay + slot_max[s];
          r.last = 1'b1;
          owed_words = {owed_words, r};
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_idx = '0;
      for (int n = 0; n < SLOTS; n++) slot_busy[n] = 1'b0;
      owed_words.delete();
      owed_cnt_o = 0;
      mismatch_cnt_o = 0;
    end else begin
      // Check the outgoing word first: nothing accepted this edge can show up yet.
      if (out_valid_i && out_ready_i) begin
        if (owed_words.size() == 0) begin
          report_mismatch("word with none owed", out_data_i.out_index, '0);
        end else begin
          want = owed_words.pop_front();
          compare_word(out_data_i, want);
        end
      end
      if (in_valid_i && in_ready_i) predict_tracker(in_data_i);
      owed_cnt_o = owed_words.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, stimulus for the fanout tracker, and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import fct_pkg::*;

  localparam int unsigned RAND_ITEMS  = 470;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDX_LO      = FAN_SH + SLOT_W;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  fct_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  fct_out_t out_data_o;

  int unsigned mismatch_cnt;
  int unsigned owed_cnt;
  int unsigned cycle_cnt;

  // Stimulus-side view of the slots, used only to aim responses
  logic [63:0] issue_idx;
  bit          slot_taken [SLOTS];
  int unsigned slot_open [SLOTS];
  logic [63:0] open_leaves [$];
  bit          steady_in;

  always #2 clk_i = ~clk_i;

  fanout_completion_tracker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  fct_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .mismatch_cnt_o (mismatch_cnt),
    .owed_cnt_o     (owed_cnt)
  );

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_word(input fct_in_t w);
    int unsigned gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_request(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3,
                              input logic [63:0] tag, input logic [63:0] stamp,
                              input logic [31:0] cpu);
    fct_in_t           w;
    logic [SLOT_W-1:0] s;
    w.command     = CMD_REQUEST;
    w.work_0      = w0;
    w.work_1      = w1;
    w.work_2      = w2;
    w.work_3      = w3;
    w.tag         = tag;
    w.end_stamp   = stamp;
    w.cpu_number  = cpu;
    w.leaf_delay  = pick64();
    w.local_delay = pick64();
    s = issue_idx[FAN_SH +: SLOT_W];
    if (!slot_taken[s]) begin
      slot_taken[s] = 1'b1;
      slot_open[s]  = FANOUT;
      for (int i = 0; i < FANOUT; i++) open_leaves = {open_leaves, issue_idx + 64'(i)};
      issue_idx = issue_idx + 64'(FANOUT);
    end
    put_word(w);
  endtask

  task automatic send_response(input logic [63:0] tag, input logic [63:0] delay,
                               input logic [63:0] local_d);
    fct_in_t           w;
    logic [SLOT_W-1:0] s;
    w.command     = CMD_RESPONSE;
    w.work_0      = pick64();
    w.work_1      = pick64();
    w.work_2      = pick64();
    w.work_3      = pick64();
    w.tag         = tag;
    w.end_stamp   = pick64();
    w.cpu_number  = 32'(pick64());
    w.leaf_delay  = delay;
    w.local_delay = local_d;
    s = tag[FAN_SH +: SLOT_W];
    if (slot_taken[s]) begin
      slot_open[s]--;
      if (slot_open[s] == 0) slot_taken[s] = 1'b0;
    end
    put_word(w);
  endtask

  task automatic send_random_request();
    send_request(pick64(), pick64(), pick64(), pick64(), pick64(), pick64(),
                 32'(pick64()));
  endtask

  // Hold off the sender until every owed word has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (owed_cnt != 0);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 12)) @(posedge clk_i);
      out_ready_i <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned plen;
    int unsigned req_pct;
    int unsigned k;
    int unsigned r;
    int unsigned j;
    logic [63:0] idx;
    logic [63:0] tag;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    issue_idx  = '0;
    steady_in  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extreme work amounts and ids; slot 0 takes indices 0..3.
    send_request('0, '1, 64'h8000_0000_0000_0000, 64'h0123_4567_89ab_cdef, '1, '0, '1);
    // Response to an idle slot, top index bits all set
    send_response('1, '1, '0);
    send_response(64'd3, 64'd7, '0);
    send_response(64'd1, '1, '0);
    send_response(64'd0, '0, '0);
    // Final response: local delay plus largest leaf delay wraps
    send_response(64'd2, 64'd5, '1);
    send_request(64'd1, 64'd2, 64'd3, 64'd4, 64'hdead_beef_0000_0001, '1, '0);
    send_request('1, '1, '1, '1, '0, 64'h5555_aaaa_5555_aaaa, 32'h8000_0001);
    // Stale response: different index, same slot as 4..7
    send_response(64'd4 + 64'(SLOTS * FANOUT), 64'd9, 64'd1);
    send_response(64'd4, 64'd2, 64'd1);
    send_response(64'd5, 64'd11, 64'd1);
    send_response(64'd6, 64'd3, 64'd1);
    // Slot already freed by the stale count
    send_response(64'd7, '1, 64'd1);
    send_response(64'd11, '0, '1);
    send_response(64'd10, '0, '1);
    send_response(64'd9, '0, '1);
    send_response(64'd8, '0, '1);
    send_response(64'd8, 64'd1, 64'd1);
    open_leaves.delete();
    drain();

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      // Open with a request-heavy phase so every slot fills and requests bounce.
      plen = (phase == 0) ? 140 : $urandom_range(40, 100);
      case ((phase == 0) ? 3 : $urandom_range(0, 3))
        0:       req_pct = 10;
        1:       req_pct = 20;
        2:       req_pct = 30;
        default: req_pct = 75;
      endcase
      steady_in = ($urandom_range(0, 3) == 0);
      for (k = 0; k < plen && sent < RAND_ITEMS; k++) begin
        if (open_leaves.size() == 0 || $urandom_range(0, 99) < req_pct) begin
          send_random_request();
          sent++;
        end else begin
          r   = $urandom_range(0, 99);
          j   = $urandom_range(0, open_leaves.size() - 1);
          idx = open_leaves[j];
          if (r < 85) begin
            open_leaves.delete(j);
            send_response(idx, pick64(), pick64());
            sent++;
          end else if (r < 93) begin
            tag = pick64();
            tag[IDX_LO-1:0] = idx[IDX_LO-1:0];
            send_response(tag, pick64(), pick64());
            sent++;
          end else begin
            send_response(pick64(), pick64(), pick64());
          end
        end
      end
      steady_in = 1'b0;
      if (phase == 1) drain();
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* fanout_completion_tracker_core.f */
hw/rtl/fct_pkg.sv
hw/rtl/fct_ram.sv
hw/rtl/fct_front.sv
hw/rtl/fct_queue.sv
hw/rtl/fct_back.sv
hw/rtl/fanout_completion_tracker_core.sv
tb/sv/fct_checker.sv
tb/sv/tb_top.sv
